// ===== rtl/pic_pkg.sv =====
`timescale 1ns / 1ps

package pic_pkg;

    localparam int NUM_SITES = 64;
    localparam int WAYS      = 4;
    localparam int SITE_W    = $clog2(NUM_SITES);
    localparam int CNT_W     = $clog2(WAYS + 1);
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

    // opcode field values
    localparam logic [2:0] OPC_RECORD    = 3'd0;
    localparam logic [2:0] OPC_LOOKUP    = 3'd1;
    localparam logic [2:0] OPC_HIT       = 3'd2;
    localparam logic [2:0] OPC_MISS      = 3'd3;
    localparam logic [2:0] OPC_CLR_SITE  = 3'd4;
    localparam logic [2:0] OPC_CLR_ALL   = 3'd5;

    typedef enum logic [2:0] {
        K_RECORD   = 3'd0,
        K_LOOKUP   = 3'd1,
        K_HIT      = 3'd2,
        K_MISS     = 3'd3,
        K_CLR_SITE = 3'd4,
        K_CLR_ALL  = 3'd5,
        K_NOP      = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SITE_W-1:0]  site;
        logic [63:0]        sig;
        logic [31:0]        code;
    } cmd_t;

    typedef struct packed {
        logic [63:0] sig;
        logic [31:0] code;
        logic [31:0] hits;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic              found;
        logic [31:0]       code;
        logic              from_fb;
        logic              mega;
        logic [CNT_W-1:0]  entries;
        logic [31:0]       calls;
        logic [31:0]       hits;
        logic [31:0]       misses;
    } result_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/pic_front.sv =====
`timescale 1ns / 1ps

module pic_front
    import pic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        opcode,
    input  logic [SITE_W-1:0] site_index,
    input  logic [63:0]       type_key,
    input  logic [31:0]       code_handle,
    output logic              q_valid,
    output cmd_t              q_cmd,
    input  logic              q_pop
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    cmd_t              cmd_in;

    // decode
    always_comb
    begin
        cmd_in.site = site_index;
        cmd_in.sig  = type_key;
        cmd_in.code = code_handle;
        unique case (opcode)
            OPC_RECORD:   cmd_in.kind = K_RECORD;
            OPC_LOOKUP:   cmd_in.kind = K_LOOKUP;
            OPC_HIT:      cmd_in.kind = K_HIT;
            OPC_MISS:     cmd_in.kind = K_MISS;
            OPC_CLR_SITE: cmd_in.kind = K_CLR_SITE;
            OPC_CLR_ALL:  cmd_in.kind = K_CLR_ALL;
            default:      cmd_in.kind = K_NOP;
        endcase
    end

    assign busy    = (cnt_reg == QCNT_W'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = slot_reg[head_reg];

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            tail_next = (tail_reg == QPTR_W'(QDEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (q_pop)
        begin
            head_next = (head_reg == QPTR_W'(QDEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= cmd_in;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH)) else $error("queue overfilled");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !q_pop |=> busy) else $error("full queue drained without pop");

endmodule

// ===== rtl/pic_back.sv =====
`timescale 1ns / 1ps

module pic_back
    import pic_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    enable,
    input  logic    q_valid,
    input  cmd_t    q_cmd,
    output logic    q_pop,
    output logic    res_valid,
    output result_t res
);

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // per-site control in flops
    logic [NUM_SITES-1:0] valid_reg;
    logic [NUM_SITES-1:0] mega_reg;
    logic [NUM_SITES-1:0] fbv_reg;
    logic [CNT_W-1:0]     count_reg [NUM_SITES];

    // entry rows and fallback codes in memory
    row_t        row_mem [NUM_SITES];
    logic [31:0] fb_mem  [NUM_SITES];

    cmd_t             cmd_reg;
    row_t             row_reg;
    logic [31:0]      fb_reg;
    logic [CNT_W-1:0] count_rd_reg;

    logic [31:0] calls_reg, calls_next;
    logic [31:0] hits_reg, hits_next;
    logic [31:0] misses_reg, misses_next;

    logic        res_valid_reg;
    result_t     res_reg, res_next;

    // execute-cycle signals
    logic              exists;
    logic [CNT_W-1:0]  cnt;
    logic [WAYS-1:0]   match;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  best_way;
    logic [31:0]       best_cnt;
    row_t              row_next;
    logic              row_we;
    logic              fb_we;
    logic [31:0]       fb_wdata;
    logic              s_valid_n, s_mega_n, s_fbv_n;
    logic [CNT_W-1:0]  s_count_n;
    logic              site_we;
    logic              clr_all;

    assign q_pop = (state_reg == S_LOAD) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: if (q_valid) state_next = S_EXEC;
            S_EXEC: state_next = S_LOAD;
            default: state_next = S_LOAD;
        endcase
    end

    // way match and most-hit search on the registered row
    always_comb
    begin
        exists = valid_reg[cmd_reg.site];
        cnt    = exists ? count_rd_reg : '0;
        for (int i = 0; i < WAYS; i++)
        begin
            match[i] = (CNT_W'(i) < cnt) && (row_reg[i].sig == cmd_reg.sig);
        end
        hit     = |match;
        hit_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i]) hit_way = WAY_W'(i);
        end
        best_way = '0;
        best_cnt = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if ((CNT_W'(i) < cnt) && (row_reg[i].hits > best_cnt))
            begin
                best_cnt = row_reg[i].hits;
                best_way = WAY_W'(i);
            end
        end
    end

    always_comb
    begin
        row_next    = row_reg;
        row_we      = 1'b0;
        fb_we       = 1'b0;
        fb_wdata    = row_reg[best_way].code;
        s_valid_n   = exists;
        s_mega_n    = mega_reg[cmd_reg.site];
        s_fbv_n     = fbv_reg[cmd_reg.site];
        s_count_n   = cnt;
        site_we     = 1'b0;
        clr_all     = 1'b0;
        calls_next  = calls_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        res_next    = '0;

        case (cmd_reg.kind)
            K_RECORD:
            begin
                if (enable)
                begin
                    site_we = 1'b1;
                    if (!exists)
                    begin
                        s_valid_n = 1'b1;
                        s_mega_n  = 1'b0;
                        s_fbv_n   = 1'b0;
                    end
                    if (hit)
                    begin
                        row_we                 = 1'b1;
                        row_next[hit_way].code = cmd_reg.code;
                        row_next[hit_way].hits = sat_inc(row_reg[hit_way].hits);
                    end
                    else if (cnt < CNT_W'(WAYS))
                    begin
                        row_we                            = 1'b1;
                        row_next[cnt[WAY_W-1:0]].sig      = cmd_reg.sig;
                        row_next[cnt[WAY_W-1:0]].code     = cmd_reg.code;
                        row_next[cnt[WAY_W-1:0]].hits     = 32'd1;
                        s_count_n                         = cnt + 1'b1;
                    end
                    else
                    begin
                        // full site turns megamorphic, new type dropped
                        s_mega_n  = 1'b1;
                        s_count_n = '0;
                        if (best_cnt != '0)
                        begin
                            s_fbv_n = 1'b1;
                            fb_we   = 1'b1;
                        end
                    end
                end
            end
            K_LOOKUP:
            begin
                if (enable && exists)
                begin
                    if (hit)
                    begin
                        row_we                 = 1'b1;
                        row_next[hit_way].hits = sat_inc(row_reg[hit_way].hits);
                        res_next.found         = 1'b1;
                        res_next.code          = row_reg[hit_way].code;
                    end
                    else if (mega_reg[cmd_reg.site] && fbv_reg[cmd_reg.site])
                    begin
                        res_next.found   = 1'b1;
                        res_next.code    = fb_reg;
                        res_next.from_fb = 1'b1;
                    end
                end
            end
            K_HIT:
            begin
                calls_next = sat_inc(calls_reg);
                hits_next  = sat_inc(hits_reg);
                if (exists && hit)
                begin
                    row_we                 = 1'b1;
                    row_next[hit_way].hits = sat_inc(row_reg[hit_way].hits);
                end
            end
            K_MISS:
            begin
                calls_next  = sat_inc(calls_reg);
                misses_next = sat_inc(misses_reg);
            end
            K_CLR_SITE:
            begin
                site_we   = 1'b1;
                s_valid_n = 1'b0;
            end
            K_CLR_ALL:
            begin
                clr_all     = 1'b1;
                s_valid_n   = 1'b0;
                calls_next  = '0;
                hits_next   = '0;
                misses_next = '0;
            end
            default:
            begin
            end
        endcase

        res_next.mega    = s_valid_n && s_mega_n;
        res_next.entries = s_valid_n ? s_count_n : '0;
        res_next.calls   = calls_next;
        res_next.hits    = hits_next;
        res_next.misses  = misses_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            valid_reg     <= '0;
            mega_reg      <= '0;
            fbv_reg       <= '0;
            calls_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= (state_reg == S_EXEC);
            if (state_reg == S_EXEC)
            begin
                calls_reg  <= calls_next;
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
                if (clr_all)
                begin
                    valid_reg <= '0;
                end
                else if (site_we)
                begin
                    valid_reg[cmd_reg.site] <= s_valid_n;
                    mega_reg[cmd_reg.site]  <= s_mega_n;
                    fbv_reg[cmd_reg.site]   <= s_fbv_n;
                end
            end
        end
    end

    // count is meaningful only while the site is valid
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_EXEC) && site_we)
        begin
            count_reg[cmd_reg.site] <= s_count_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg      <= q_cmd;
            row_reg      <= row_mem[q_cmd.site];
            fb_reg       <= fb_mem[q_cmd.site];
            count_rd_reg <= count_reg[q_cmd.site];
        end
        if ((state_reg == S_EXEC) && row_we)
        begin
            row_mem[cmd_reg.site] <= row_next;
        end
        if ((state_reg == S_EXEC) && fb_we)
        begin
            fb_mem[cmd_reg.site] <= fb_wdata;
        end
        if (state_reg == S_EXEC)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_res_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(state_reg == S_EXEC)) else $error("result without exec");
    a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_LOAD) else $error("exec held");
    a_fb_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.from_fb |-> res_reg.found) else $error("fallback not found");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> cnt <= CNT_W'(WAYS)) else $error("entry count over ways");

endmodule

// ===== rtl/polymorphic_inline_cache_core.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// command   start / busy             opcode, site_index, type_key, code_handle
// config    cfg_valid / cfg_ready    cfg_data (enable)
// result    done (one-cycle strobe)  found, result_code, from_fallback, site_megamorphic,
//                                    site_entries, calls_total, hits_total, misses_total
//
// In the back end, state S_LOAD reads the site's entry row and fallback code from memory,
// and state S_EXEC matches, updates, writes back and registers the result.
// done follows the result register; the back end ends each item before loading the next.
// A 2-item queue takes commands while the back end works; busy is high when it is full.
// Reset clears all sites, the global counters and sets enable; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.

module polymorphic_inline_cache_core
    import pic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        opcode,
    input  logic [SITE_W-1:0] site_index,
    input  logic [63:0]       type_key,
    input  logic [31:0]       code_handle,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    output logic              done,
    output logic              found,
    output logic [31:0]       result_code,
    output logic              from_fallback,
    output logic              site_megamorphic,
    output logic [CNT_W-1:0]  site_entries,
    output logic [31:0]       calls_total,
    output logic [31:0]       hits_total,
    output logic [31:0]       misses_total
);

    logic    enable_reg;
    logic    q_valid;
    logic    q_pop;
    cmd_t    q_cmd;
    result_t res;

    // config register: always ready; the user is to write it only while idle, the block has no check for this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            enable_reg <= cfg_data;
        end
    end

    // front: decode and queue
    pic_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .site_index     (site_index),
        .type_key       (type_key),
        .code_handle    (code_handle),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop)
    );

    // back: read-modify-write of the site row
    pic_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .res_valid (done),
        .res       (res)
    );

    assign found            = res.found;
    assign result_code      = res.code;
    assign from_fallback    = res.from_fb;
    assign site_megamorphic = res.mega;
    assign site_entries     = res.entries;
    assign calls_total      = res.calls;
    assign hits_total       = res.hits;
    assign misses_total     = res.misses;

endmodule
